[design/nfasr_pkg.sv]
// ============================================================================
// nfasr_pkg - shared types and constants of the NFA string recogniser
// Sizes, command codes, register indexes and the queue entry layout.
// ============================================================================
`default_nettype none

package nfasr_pkg;

    // Automaton and table sizes
    localparam int MAX_STATES    = 16;
    localparam int MAX_RELATIONS = 64;
    localparam int ST_W          = $clog2(MAX_STATES);
    localparam int NS_W          = $clog2(MAX_STATES + 1);
    localparam int RI_W          = $clog2(MAX_RELATIONS);
    localparam int NR_W          = $clog2(MAX_RELATIONS + 1);
    localparam int SYM_W         = 8;
    localparam int REL_W         = 2 * ST_W + SYM_W;

    // Command queue between front and back
    localparam int QUEUE_DEPTH   = 4;
    localparam int QA_W          = $clog2(QUEUE_DEPTH);
    localparam int QC_W          = $clog2(QUEUE_DEPTH + 1);

    // Stream widths: tdata fields padded to whole bytes
    localparam int CMD_W         = 2;
    localparam int S_FIELD_W     = RI_W + REL_W + SYM_W;
    localparam int S_DATA_W      = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_DATA_W      = ((MAX_STATES + 2 + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELATION_COUNT = 1'b1;

    // Command codes of the input stream
    typedef enum logic [CMD_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_PROC    = 2'd1,
        OP_RESTART = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    // One classified command waiting in the queue
    typedef struct packed {
        t_op                op;
        logic [RI_W-1:0]    index;
        logic [REL_W-1:0]   rel;      // from, to, symbol from the top bit down
        logic [SYM_W-1:0]   symbol;
        logic               last;
    } t_cmd;

    // One result item
    typedef struct packed {
        logic [MAX_STATES-1:0] mask;
        logic                  accepted;
        logic                  alive;
    } t_result;

    // Back-end status seen by the top level
    typedef struct packed {
        logic scanning;
        logic out_load;
    } t_stat;

endpackage

`default_nettype wire

[design/nfasr_ram.sv]
// ============================================================================
// nfasr_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module nfasr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  wire logic [WIDTH-1:0]             i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]     i_raddr,
    output logic      [WIDTH-1:0]             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[design/nfasr_front.sv]
// ============================================================================
// nfasr_front - input stage of the NFA string recogniser
// Accepts stream items, classifies the command and queues them for the back.
// ============================================================================
`default_nettype none

module nfasr_front
    import nfasr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [S_FIELD_W-1:0] i_data,
    input  wire logic [CMD_W-1:0]     i_user,
    input  wire logic                 i_last,
    output logic                      o_head_valid,
    output t_cmd                      o_head,
    input  wire logic                 i_pop
);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [QA_W-1:0]  r_wp, n_wp;
    logic [QA_W-1:0]  r_rp, n_rp;
    logic [QC_W-1:0]  r_cnt, n_cnt;
    t_cmd             w_cmd;
    logic             w_push;

    // Classify the incoming item
    always_comb begin
        case (i_user)
            OP_LOAD:    w_cmd.op = OP_LOAD;
            OP_PROC:    w_cmd.op = OP_PROC;
            OP_RESTART: w_cmd.op = OP_RESTART;
            default:    w_cmd.op = OP_NOP;
        endcase
        w_cmd.index  = i_data[RI_W-1:0];
        w_cmd.rel    = {i_data[RI_W +: ST_W], i_data[RI_W + ST_W +: ST_W],
                        i_data[RI_W + 2 * ST_W +: SYM_W]};
        w_cmd.symbol = i_data[RI_W + REL_W +: SYM_W];
        w_cmd.last   = i_last;
    end

    assign o_ready      = (r_cnt != QC_W'(QUEUE_DEPTH));
    assign w_push       = i_valid && o_ready;
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rp];

    // Advance the queue pointers
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = r_rp + 1'b1;
        end
        case ({w_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Hold queue entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

[design/nfasr_back.sv]
// ============================================================================
// nfasr_back - execution stage of the NFA string recogniser
// Writes relations, scans the table one slot a cycle, drives the result item.
// ============================================================================
`default_nettype none

module nfasr_back
    import nfasr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [NS_W-1:0]   i_state_count,
    input  wire logic [NR_W-1:0]   i_relation_count,
    input  wire logic              i_head_valid,
    input  wire t_cmd              i_head,
    output logic                   o_pop,
    output logic                   o_ram_we,
    output logic [RI_W-1:0]        o_ram_waddr,
    output logic [REL_W-1:0]       o_ram_wdata,
    output logic [RI_W-1:0]        o_ram_raddr,
    input  wire logic [REL_W-1:0]  i_ram_rdata,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_result                o_out,
    output t_stat                  o_stat
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [MAX_STATES-1:0] r_active, n_active;
    logic                  r_dead, n_dead;
    logic [NR_W-1:0]       r_k, n_k;
    logic                  r_rd_valid, n_rd_valid;
    logic [MAX_STATES-1:0] r_acc, n_acc;
    logic [SYM_W-1:0]      r_sym, n_sym;
    logic                  r_last, n_last;
    logic                  r_out_valid;
    t_result               r_out;
    t_result               w_res;
    logic                  w_out_load;
    logic                  w_out_free;
    logic [ST_W-1:0]       w_src, w_dst;
    logic [SYM_W-1:0]      w_rsym;
    logic                  w_hit;
    logic [NS_W-1:0]       w_fin;

    // Split the table word read back
    assign w_src  = i_ram_rdata[REL_W-1 -: ST_W];
    assign w_dst  = i_ram_rdata[SYM_W +: ST_W];
    assign w_rsym = i_ram_rdata[SYM_W-1:0];
    assign w_hit  = (w_rsym == r_sym) && (NS_W'(w_src) < i_state_count)
                    && (NS_W'(w_dst) < i_state_count) && r_active[w_src];
    assign w_fin  = i_state_count - 1'b1;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_ram_waddr = i_head.index;
    assign o_ram_wdata = i_head.rel;
    assign o_ram_raddr = r_k[RI_W-1:0];

    // Sequence commands
    always_comb begin
        n_state    = r_state;
        n_active   = r_active;
        n_dead     = r_dead;
        n_k        = r_k;
        n_rd_valid = 1'b0;
        n_acc      = r_acc;
        n_sym      = r_sym;
        n_last     = r_last;
        o_pop      = 1'b0;
        o_ram_we   = 1'b0;
        w_out_load = 1'b0;
        w_res      = '{mask: r_active, accepted: 1'b0, alive: (r_active != '0)};
        case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    case (i_head.op)
                        OP_LOAD: begin
                            if (w_out_free) begin
                                o_pop      = 1'b1;
                                o_ram_we   = 1'b1;
                                w_out_load = 1'b1;
                            end
                        end
                        OP_RESTART: begin
                            if (w_out_free) begin
                                o_pop      = 1'b1;
                                w_out_load = 1'b1;
                                n_active   = MAX_STATES'(1);
                                n_dead     = 1'b0;
                                w_res      = '{mask: MAX_STATES'(1),
                                               accepted: (w_fin == '0), alive: 1'b1};
                            end
                        end
                        OP_PROC: begin
                            if (r_dead) begin
                                if (w_out_free) begin
                                    o_pop      = 1'b1;
                                    w_out_load = 1'b1;
                                    w_res      = '{mask: '0, accepted: 1'b0, alive: 1'b0};
                                end
                            end else begin
                                o_pop   = 1'b1;
                                n_sym   = i_head.symbol;
                                n_last  = i_head.last;
                                n_k     = '0;
                                n_acc   = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            if (w_out_free) begin
                                o_pop      = 1'b1;
                                w_out_load = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Issue one table read a cycle, fold in the previous one
                if (r_rd_valid && w_hit) begin
                    n_acc = r_acc | (MAX_STATES'(1) << w_dst);
                end
                if (r_k != i_relation_count) begin
                    n_k        = r_k + 1'b1;
                    n_rd_valid = 1'b1;
                end else if (!r_rd_valid) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                w_res = '{mask: r_acc,
                          accepted: r_last && r_acc[w_fin[ST_W-1:0]],
                          alive: (r_acc != '0)};
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_active   = r_acc;
                    n_dead     = (r_acc == '0);
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= MAX_STATES'(1);
            r_dead      <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_active   <= n_active;
            r_dead     <= n_dead;
            r_rd_valid <= n_rd_valid;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_acc  <= n_acc;
        r_sym  <= n_sym;
        r_last <= n_last;
        if (w_out_load) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;
    assign o_stat.scanning = (r_state == ST_SCAN);
    assign o_stat.out_load = w_out_load;

endmodule

`default_nettype wire

[design/nfa_string_recognizer_top.sv]
// ============================================================================
// nfa_string_recognizer_top - NFA string recogniser
// Loads transition relations and runs a nondeterministic automaton on bytes.
// ============================================================================
//  Channel   Direction  Handshake          Payload
//  s_axis    in         tvalid / tready    tuser command; tdata relation, symbol; tlast
//  m_axis    out        tvalid / tready    tdata alive, accepted, active_states
//  cfg       in         we (no stall)      index, write data
//
//  Load, restart and unused commands are handled in the idle state of the back
//  end; a symbol scans the relation table through its single read port one
//  slot a cycle, then retires the last read and loads the result. A symbol
//  after rejection is answered from the idle state without a scan.
//  Synchronous active-low reset; the relation table is not cleared.
//  A four-entry command queue lets input accept while a result is stalled.
// ============================================================================
`default_nettype none

module nfa_string_recognizer_top
    import nfasr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // rel_index[5:0], from_state[9:6], to_state[13:10], rel_symbol[21:14],
    // symbol[29:22], zero fill[31:30]
    input  wire logic [S_DATA_W-1:0]   i_s_axis_tdata,
    // command[1:0]
    input  wire logic [CMD_W-1:0]      i_s_axis_tuser,
    input  wire logic                  i_s_axis_tlast,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // alive[0], accepted[1], active_states[17:2], zero fill[23:18]
    output logic [M_DATA_W-1:0]        o_m_axis_tdata,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [NS_W-1:0]   r_state_count;
    logic [NR_W-1:0]   r_relation_count;
    logic              w_head_valid;
    t_cmd              w_head;
    logic              w_pop;
    logic              w_ram_we;
    logic [RI_W-1:0]   w_ram_waddr;
    logic [REL_W-1:0]  w_ram_wdata;
    logic [RI_W-1:0]   w_ram_raddr;
    logic [REL_W-1:0]  w_ram_rdata;
    t_result           w_out;
    t_stat             w_stat;

    // Hold configuration, clamped to the supported ranges
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_count    <= NS_W'(MAX_STATES);
            r_relation_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STATE_COUNT: begin
                    if (i_cfg_wdata[NS_W-1:0] == '0) begin
                        r_state_count <= NS_W'(1);
                    end else if (i_cfg_wdata[NS_W-1:0] > NS_W'(MAX_STATES)) begin
                        r_state_count <= NS_W'(MAX_STATES);
                    end else begin
                        r_state_count <= i_cfg_wdata[NS_W-1:0];
                    end
                end
                CFG_RELATION_COUNT: begin
                    if (i_cfg_wdata[NR_W-1:0] > NR_W'(MAX_RELATIONS)) begin
                        r_relation_count <= NR_W'(MAX_RELATIONS);
                    end else begin
                        r_relation_count <= i_cfg_wdata[NR_W-1:0];
                    end
                end
                default: begin
                    r_state_count <= r_state_count;
                end
            endcase
        end
    end

    nfasr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_data       (i_s_axis_tdata[S_FIELD_W-1:0]),
        .i_user       (i_s_axis_tuser),
        .i_last       (i_s_axis_tlast),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    nfasr_ram #(
        .WIDTH (REL_W),
        .DEPTH (MAX_RELATIONS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    nfasr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_state_count    (r_state_count),
        .i_relation_count (r_relation_count),
        .i_head_valid     (w_head_valid),
        .i_head           (w_head),
        .o_pop            (w_pop),
        .o_ram_we         (w_ram_we),
        .o_ram_waddr      (w_ram_waddr),
        .o_ram_wdata      (w_ram_wdata),
        .o_ram_raddr      (w_ram_raddr),
        .i_ram_rdata      (w_ram_rdata),
        .o_out_valid      (o_m_axis_tvalid),
        .i_out_ready      (i_m_axis_tready),
        .o_out            (w_out),
        .o_stat           (w_stat)
    );

    assign o_m_axis_tdata = {(M_DATA_W - MAX_STATES - 2)'(0), w_out};

    // Checks on the internal hand-off between the stages
    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid)
        else $error("queue popped while empty");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> !w_stat.scanning)
        else $error("relation written during a table scan");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.out_load |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("pending result overwritten");

    a_state_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state_count != '0) && (r_state_count <= NS_W'(MAX_STATES)))
        else $error("state count out of range");

endmodule

`default_nettype wire

[test/tb_nfa_string_recognizer_top.sv]
// ============================================================================
// tb_nfa_string_recognizer_top - testbench of the NFA string recogniser
// Loads relation tables, feeds strings and control items on the input stream,
// and predicts every result item from a behavioural copy of the automaton.
// Each result is checked field by field in order. Both stream sides idle at
// random, the result side holds off for a long stretch once, and the
// registers are changed between phases while the block is idle.
// ============================================================================

module tb_nfa_string_recognizer_top;

    timeunit 1ns;
    timeprecision 1ps;

    import nfasr_pkg::*;

    localparam int ITEM_TARGET = 1100;
    localparam int HOLD_CYCLES = 400;
    localparam int SCAN_CYCLES = MAX_RELATIONS + 3;

    // One input item, the lowest tdata field just above the command,
    // which travels in tuser
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic [SYM_W-1:0] rel_sym;
        logic [ST_W-1:0]  dst;
        logic [ST_W-1:0]  src;
        logic [RI_W-1:0]  slot;
        t_op              op;
    } t_stream_cmd;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [S_DATA_W-1:0]   i_s_axis_tdata;
    logic [CMD_W-1:0]      i_s_axis_tuser;
    logic                  i_s_axis_tlast;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [M_DATA_W-1:0]   o_m_axis_tdata;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    // Behavioural copy of the automaton
    logic [REL_W-1:0]      rel_tab [MAX_RELATIONS];
    bit                    slot_written [MAX_RELATIONS];
    logic [MAX_STATES-1:0] act_set = 1;
    bit                    rejected = 1'b0;
    logic [NS_W-1:0]       cfg_states = NS_W'(MAX_STATES);
    logic [NR_W-1:0]       cfg_rels = '0;

    t_result predicted_sets [$];
    int      fault_count = 0;
    int      items_taken = 0;
    bit      idling = 1'b1;
    bit      hold_results = 1'b0;

    nfa_string_recognizer_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

    // Advance the automaton by one item and return the result it gives
    function automatic t_result advance_automaton(input t_stream_cmd c, input logic is_last);
        t_result               r;
        logic [MAX_STATES-1:0] nxt;
        logic [REL_W-1:0]      e;
        int                    ns;
        int                    nr;
        int                    fin;
        ns  = (cfg_states == 0) ? 1 : ((cfg_states > MAX_STATES) ? MAX_STATES : cfg_states);
        nr  = (cfg_rels > MAX_RELATIONS) ? MAX_RELATIONS : cfg_rels;
        fin = ns - 1;
        r   = '0;
        case (c.op)
            OP_LOAD: begin
                rel_tab[c.slot]      = {c.src, c.dst, c.rel_sym};
                slot_written[c.slot] = 1'b1;
                r.alive = |act_set;
                r.mask  = act_set;
            end
            OP_RESTART: begin
                act_set    = 1;
                rejected   = 1'b0;
                r.alive    = 1'b1;
                r.accepted = (fin == 0);
                r.mask     = act_set;
            end
            OP_PROC: begin
                // a rejected string ignores further symbols until restart
                if (!rejected) begin
                    nxt = '0;
                    for (int k = 0; k < nr; k++) begin
                        e = rel_tab[k];
                        if (e[SYM_W-1:0] == c.sym && e[REL_W-1 -: ST_W] < ns
                                && e[SYM_W +: ST_W] < ns && act_set[e[REL_W-1 -: ST_W]])
                            nxt[e[SYM_W +: ST_W]] = 1'b1;
                    end
                    act_set    = nxt;
                    rejected   = (nxt == '0);
                    r.alive    = |nxt;
                    r.accepted = is_last ? nxt[fin] : 1'b0;
                    r.mask     = nxt;
                end
            end
            default: begin
                r.alive = |act_set;
                r.mask  = act_set;
            end
        endcase
        return r;
    endfunction

    function automatic bit table_full();
        foreach (slot_written[i])
            if (!slot_written[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void report_fault(input string what, input t_result want,
                                         input t_result got);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: %s: expected alive %0b accepted %0b mask %04h,",
                     $realtime, what, want.alive, want.accepted, want.mask,
                     " got alive %0b accepted %0b mask %04h",
                     got.alive, got.accepted, got.mask);
    endfunction

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[$bits(t_result)-1:0];
            if (predicted_sets.size() == 0) begin
                report_fault("result with no item pending", '0, got);
            end else begin
                want = predicted_sets.pop_front();
                if (got.alive !== want.alive || got.accepted !== want.accepted
                        || got.mask !== want.mask)
                    report_fault("result mismatch", want, got);
            end
        end
    end

    // Drive the result side: random stalls, or one long hold when asked
    initial begin : result_sink
        int unsigned n;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_results) begin
                i_m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_results = 1'b0;
            end else if (idling && $urandom_range(0, 6) == 0) begin
                i_m_axis_tready = 1'b0;
                n = $urandom_range(1, 15);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    // Offer one item, wait for it to be taken and record its prediction
    task automatic send_item(input t_stream_cmd c, input logic is_last);
        int unsigned gap;
        if (idling && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = c.op;
        i_s_axis_tdata  = S_DATA_W'({c.sym, c.rel_sym, c.dst, c.src, c.slot});
        i_s_axis_tlast  = is_last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted_sets.push_back(advance_automaton(c, is_last));
        items_taken++;
    endtask

    // Random filler in every field that the command does not use
    function automatic t_stream_cmd scramble_cmd(input t_op op);
        t_stream_cmd c;
        c    = t_stream_cmd'($urandom);
        c.op = op;
        return c;
    endfunction

    task automatic send_load(input int slot, input int src, input int dst,
                             input logic [SYM_W-1:0] rsym);
        t_stream_cmd c;
        c         = scramble_cmd(OP_LOAD);
        c.slot    = RI_W'(slot);
        c.src     = ST_W'(src);
        c.dst     = ST_W'(dst);
        c.rel_sym = rsym;
        send_item(c, $urandom_range(0, 1));
    endtask

    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic is_last);
        t_stream_cmd c;
        c     = scramble_cmd(OP_PROC);
        c.sym = sym;
        send_item(c, is_last);
    endtask

    task automatic send_control(input t_op op);
        send_item(scramble_cmd(op), $urandom_range(0, 1));
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (predicted_sets.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int val);
        drain();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = CFG_DATA_W'(val);
        if (idx == CFG_STATE_COUNT)
            cfg_states = NS_W'(val);
        else
            cfg_rels = NR_W'(val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Mostly a state in use, now and then any state
    function automatic int pick_state(input int ns_eff);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, MAX_STATES - 1);
        return $urandom_range(0, ns_eff - 1);
    endfunction

    // Empty relation list after reset: reject, ignore, report, restart
    task automatic test_empty_table();
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b1);
        send_control(OP_NOP);
        send_control(OP_RESTART);
    endtask

    // Small automaton for "a a* b" with relations that must not fire
    task automatic test_small_automaton();
        send_load(0, 0, 1, 8'h61);
        send_load(1, 0, 0, 8'h61);
        send_load(2, 1, 2, 8'h62);
        send_load(3, 2, MAX_STATES - 1, 8'h62);   // target beyond the states in use
        send_load(4, MAX_STATES - 1, 1, 8'h61);   // source beyond the states in use
        send_load(MAX_RELATIONS - 1, MAX_STATES - 1, MAX_STATES - 1, 8'hFF);
        write_register(CFG_STATE_COUNT, 3);
        write_register(CFG_RELATION_COUNT, 5);
        send_control(OP_RESTART);
        send_symbol(8'h61, 1'b0);
        send_symbol(8'h61, 1'b0);
        send_symbol(8'h62, 1'b1);
        // carry on past the last symbol without restart, then die
        send_symbol(8'h62, 1'b0);
        send_symbol(8'h61, 1'b1);
        send_control(OP_RESTART);
        send_symbol(8'h61, 1'b0);
        send_load(5, 0, 2, 8'h62);
        send_control(OP_NOP);
        send_symbol(8'h62, 1'b1);
    endtask

    // State count zero, above the maximum, and no relations in use
    task automatic test_count_extremes();
        write_register(CFG_STATE_COUNT, 0);
        send_control(OP_RESTART);
        send_symbol(8'h61, 1'b1);
        write_register(CFG_STATE_COUNT, 31);
        send_control(OP_RESTART);
        send_symbol(8'h61, 1'b1);
        write_register(CFG_RELATION_COUNT, 0);
        send_symbol(8'h61, 1'b0);
    endtask

    // Hold the result side while items keep coming, so that the input stalls
    task automatic test_result_backpressure();
        write_register(CFG_STATE_COUNT, 3);
        write_register(CFG_RELATION_COUNT, 5);
        hold_results = 1'b1;
        send_control(OP_RESTART);
        repeat (12) send_symbol($urandom_range(0, 1) ? 8'h61 : 8'h62, $urandom_range(0, 1));
        drain();
    endtask

    // One phase: fresh relations over a small alphabet, then several strings
    task automatic run_automaton_phase(input int rel_val);
        logic [SYM_W-1:0] alpha [4];
        int               n_alpha;
        int               ns_val;
        int               ns_eff;
        int               n_load;
        int               len;
        t_stream_cmd      c;
        n_alpha = $urandom_range(1, 4);
        foreach (alpha[i]) alpha[i] = $urandom_range(0, 255);
        case ($urandom_range(0, 11))
            0:       ns_val = $urandom_range(0, 1);
            1:       ns_val = $urandom_range(MAX_STATES + 1, 31);
            2, 3:    ns_val = $urandom_range(9, MAX_STATES);
            default: ns_val = $urandom_range(2, 8);
        endcase
        ns_eff = (ns_val < 1) ? 1 : ((ns_val > MAX_STATES) ? MAX_STATES : ns_val);
        n_load = (rel_val > MAX_RELATIONS) ? MAX_RELATIONS : rel_val;
        idling = ($urandom_range(0, 4) != 0);
        for (int k = 0; k < n_load; k++)
            send_load(k, pick_state(ns_eff), pick_state(ns_eff),
                      alpha[$urandom_range(0, n_alpha - 1)]);
        write_register(CFG_STATE_COUNT, ns_val);
        write_register(CFG_RELATION_COUNT, rel_val);
        repeat ($urandom_range(3, 6)) begin
            if ($urandom_range(0, 7) != 0)
                send_control(OP_RESTART);
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                // stray items inside a string
                if ($urandom_range(0, 11) == 0) begin
                    c = scramble_cmd($urandom_range(0, 1) ? OP_NOP : OP_LOAD);
                    send_item(c, $urandom_range(0, 1));
                end
                if ($urandom_range(0, 11) == 0)
                    send_symbol($urandom_range(0, 255), i == len - 1);
                else
                    send_symbol(alpha[$urandom_range(0, n_alpha - 1)], i == len - 1);
            end
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 2))
                    send_symbol(alpha[$urandom_range(0, n_alpha - 1)], $urandom_range(0, 1));
        end
    endtask

    task automatic test_random_strings();
        int phase;
        int rel_val;
        phase = 0;
        while (items_taken < ITEM_TARGET - 60) begin
            if (phase == 3)
                rel_val = MAX_RELATIONS;
            else if (phase == 5)
                rel_val = 127;
            else if (phase % 9 == 7)
                rel_val = table_full() ? $urandom_range(MAX_RELATIONS + 1, 127)
                                       : $urandom_range(17, MAX_RELATIONS);
            else if (phase % 6 == 4)
                rel_val = $urandom_range(17, MAX_RELATIONS);
            else if (phase % 10 == 8)
                rel_val = 0;
            else
                rel_val = $urandom_range(1, 16);
            run_automaton_phase(rel_val);
            phase++;
        end
    endtask

    // Last stretch of three short phases with few relations
    task automatic test_quiet_tail();
        run_automaton_phase($urandom_range(1, 8));
        idling = 1'b0;
        run_automaton_phase($urandom_range(1, 8));
        run_automaton_phase($urandom_range(1, 8));
    endtask

    task automatic finish_run();
        idling = 1'b0;
        drain();
        repeat (2 * SCAN_CYCLES) @(posedge i_clk);
        if (predicted_sets.size() != 0)
            report_fault("result never came", predicted_sets[0], '0);
        if (fault_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    endtask

    initial begin : stimulus
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_s_axis_tlast  = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_wdata     = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_empty_table();
        test_small_automaton();
        test_count_extremes();
        test_result_backpressure();
        test_random_strings();
        test_quiet_tail();
        finish_run();
    end

endmodule
